// ----- rtl/camera_to_world_pose_transform_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent check wrappers used by the top-level pose transform module.
// ----------------------------------------------------------------------------
`ifndef CAMERA_TO_WORLD_POSE_TRANSFORM_ASSERT_SVH
`define CAMERA_TO_WORLD_POSE_TRANSFORM_ASSERT_SVH
`ifndef ASSERT_OFF
`define CWPT_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("pose transform check failed");
`define CWPT_NEVER(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("pose transform forbidden condition");
`else
`define CWPT_ASSERT(lbl, prop)
`define CWPT_NEVER(lbl, expr)
`endif
`endif

// ----- rtl/cwpt_pkg.sv -----
// ----------------------------------------------------------------------------
// cwpt_pkg
// Types and constants for the camera-to-world pose transform.
// ----------------------------------------------------------------------------
package cwpt_pkg;

   localparam int CSR_DATA_W = 63;

   typedef enum logic [2:0] {
      REG_ROT_ROW0   = 3'd0,
      REG_ROT_ROW1   = 3'd1,
      REG_ROT_ROW2   = 3'd2,
      REG_OFFSET     = 3'd3,
      REG_MAX_ERROR  = 3'd4,
      REG_IMG_WIDTH  = 3'd5,
      REG_IMG_HEIGHT = 3'd6,
      REG_TYPES      = 3'd7
   } csr_index_type;

   localparam logic signed [15:0] TYPE_ALWAYS_STORE = -16'sd40;

   localparam logic signed [31:0] SAT_MAX = 32'sh7FFFFFFF;
   localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

   typedef struct packed {
      logic signed [31:0] cam_x;
      logic signed [31:0] cam_y;
      logic signed [31:0] cam_z;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
      logic signed [31:0] vehicle_x;
      logic signed [31:0] vehicle_y;
      logic signed [31:0] vehicle_z;
      logic [1:0]         slot;
   } req_type;

   typedef struct packed {
      logic signed [31:0] world_x;
      logic signed [31:0] world_y;
      logic signed [31:0] world_z;
      logic [1:0]         slot_out;
      logic signed [15:0] marker_type;
      logic               store;
   } rsp_type;

   typedef struct packed {
      logic [2:0][2:0][17:0] rot;
      logic [2:0][19:0]      offset;
      logic [62:0]           max_error;
      logic [15:0]           img_width;
      logic [15:0]           img_height;
      logic [2:0][15:0]      types;
   } cfg_type;

   typedef struct packed {
      logic st1;
      logic st2;
      logic st3;
      logic st4;
      logic st5;
   } stage_en_type;

   typedef struct packed {
      logic [2:0][2:0][22:0] rq;
      logic [2:0][38:0]      body;
      logic [2:0][31:0]      veh;
      logic [1:0]            slot;
      logic signed [15:0]    marker_type;
      logic                  store;
   } mid_type;

endpackage

// ----- rtl/cwpt_body.sv -----
// ----------------------------------------------------------------------------
// cwpt_body
// Stages 1-3: camera-to-body transform, quaternion matrix, centre check.
// ----------------------------------------------------------------------------
module cwpt_body
   import cwpt_pkg::*;
(
   input  logic         clock,
   input  req_type      req,
   input  cfg_type      cfg,
   input  stage_en_type en,
   output mid_type      mid
);

   // stage 1
   logic signed [32:0] p_ff [3];
   logic signed [32:0] p_in [3];
   logic signed [31:0] qp_ff [9];
   logic signed [31:0] qp_in [9];
   logic [31:0] ax_ff, ax_in, ay_ff, ay_in;
   logic [2:0][31:0] veh1_ff;
   logic [1:0] slot1_ff;
   logic signed [15:0] type1_ff, type1_in;
   logic signed [32:0] dx, dy;

   always_comb begin
      p_in[0] = {req.cam_x[31], req.cam_x};
      p_in[1] = {req.cam_y[31], req.cam_y};
      p_in[2] = {req.cam_z[31], req.cam_z} - {req.vehicle_z[31], req.vehicle_z};
      qp_in[0] = req.quat_x * req.quat_x;
      qp_in[1] = req.quat_y * req.quat_y;
      qp_in[2] = req.quat_z * req.quat_z;
      qp_in[3] = req.quat_x * req.quat_y;
      qp_in[4] = req.quat_x * req.quat_z;
      qp_in[5] = req.quat_y * req.quat_z;
      qp_in[6] = req.quat_x * req.quat_w;
      qp_in[7] = req.quat_y * req.quat_w;
      qp_in[8] = req.quat_z * req.quat_w;
      dx = {req.cam_x[31], req.cam_x} - $signed({2'b00, cfg.img_height[15:1], 16'h0000});
      dy = {req.cam_y[31], req.cam_y} - $signed({2'b00, cfg.img_width[15:1], 16'h0000});
      ax_in = dx[32] ? 32'(-dx) : dx[31:0];
      ay_in = dy[32] ? 32'(-dy) : dy[31:0];
      unique case (req.slot)
         2'd0:    type1_in = cfg.types[0];
         2'd1:    type1_in = cfg.types[1];
         2'd2:    type1_in = cfg.types[2];
         default: type1_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en.st1) begin
         p_ff     <= p_in;
         qp_ff    <= qp_in;
         ax_ff    <= ax_in;
         ay_ff    <= ay_in;
         veh1_ff  <= {req.vehicle_z, req.vehicle_y, req.vehicle_x};
         slot1_ff <= req.slot;
         type1_ff <= type1_in;
      end
   end

   // stage 2
   logic signed [50:0] mp_ff [3][3];
   logic signed [50:0] mp_in [3][3];
   logic signed [35:0] r_full [9];
   logic signed [35:0] r_rnd [9];
   logic [2:0][2:0][22:0] rq2_ff, rq2_in;
   logic [63:0] sx_ff, sy_ff;
   logic [2:0][31:0] veh2_ff;
   logic [1:0] slot2_ff;
   logic signed [15:0] type2_ff;
   logic signed [35:0] q2 [9];
   logic signed [35:0] one_q;

   always_comb begin
      one_q = 36'sd1 <<< 28;
      for (int i = 0; i < 9; i++) begin
         q2[i] = 36'(qp_ff[i]) <<< 1;
      end
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            mp_in[r][c] = $signed(cfg.rot[r][c]) * p_ff[c];
         end
      end
      r_full[0] = one_q - (q2[1] + q2[2]);
      r_full[1] = q2[3] - q2[8];
      r_full[2] = q2[4] + q2[7];
      r_full[3] = q2[3] + q2[8];
      r_full[4] = one_q - (q2[0] + q2[2]);
      r_full[5] = q2[5] - q2[6];
      r_full[6] = q2[4] - q2[7];
      r_full[7] = q2[5] + q2[6];
      r_full[8] = one_q - (q2[0] + q2[1]);
      for (int i = 0; i < 9; i++) begin
         r_rnd[i] = (r_full[i] + 36'sd2048) >>> 12;
         rq2_in[i / 3][i % 3] = r_rnd[i][22:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en.st2) begin
         mp_ff    <= mp_in;
         rq2_ff   <= rq2_in;
         sx_ff    <= ax_ff * ax_ff;
         sy_ff    <= ay_ff * ay_ff;
         veh2_ff  <= veh1_ff;
         slot2_ff <= slot1_ff;
         type2_ff <= type1_ff;
      end
   end

   // stage 3
   logic signed [53:0] acc [3];
   logic signed [53:0] acc_r [3];
   logic [2:0][38:0] body_in;
   logic [64:0] sum_sq;
   logic store_in;
   mid_type mid_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         acc[r] = (54'($signed(cfg.offset[r])) <<< 16) + 54'(mp_ff[r][0])
                  + 54'(mp_ff[r][1]) + 54'(mp_ff[r][2]);
         acc_r[r] = (acc[r] + 54'sd16384) >>> 15;
         body_in[r] = acc_r[r][38:0];
      end
      sum_sq = {1'b0, sx_ff} + {1'b0, sy_ff};
      store_in = ((sx_ff < {1'b0, cfg.max_error}) && (sy_ff < {1'b0, cfg.max_error})
                  && (sum_sq < {2'b00, cfg.max_error}))
                 || (type2_ff == TYPE_ALWAYS_STORE);
   end

   always_ff @(posedge clock) begin
      if (en.st3) begin
         mid_ff.rq          <= rq2_ff;
         mid_ff.body        <= body_in;
         mid_ff.veh         <= veh2_ff;
         mid_ff.slot        <= slot2_ff;
         mid_ff.marker_type <= type2_ff;
         mid_ff.store       <= store_in;
      end
   end

   assign mid = mid_ff;

endmodule

// ----- rtl/cwpt_world.sv -----
// ----------------------------------------------------------------------------
// cwpt_world
// Stages 4-5: quaternion rotation, vehicle offset and saturation.
// ----------------------------------------------------------------------------
module cwpt_world
   import cwpt_pkg::*;
(
   input  logic         clock,
   input  mid_type      mid,
   input  stage_en_type en,
   output rsp_type      rsp
);

   logic signed [61:0] pr_ff [3][3];
   logic signed [61:0] pr_in [3][3];
   logic [2:0][31:0] veh4_ff;
   logic [1:0] slot4_ff;
   logic signed [15:0] type4_ff;
   logic store4_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            pr_in[r][c] = $signed(mid.rq[r][c]) * $signed(mid.body[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en.st4) begin
         pr_ff     <= pr_in;
         veh4_ff   <= mid.veh;
         slot4_ff  <= mid.slot;
         type4_ff  <= mid.marker_type;
         store4_ff <= mid.store;
      end
   end

   logic signed [63:0] acc [3];
   logic signed [63:0] acc_r [3];
   logic signed [48:0] wsum [3];
   logic signed [31:0] wsat [3];
   rsp_type rsp_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         acc[r] = 64'(pr_ff[r][0]) + 64'(pr_ff[r][1]) + 64'(pr_ff[r][2]);
         acc_r[r] = (acc[r] + 64'sd32768) >>> 16;
         wsum[r] = acc_r[r][48:0] + 49'($signed(veh4_ff[r]));
         if (wsum[r] > 49'(SAT_MAX)) begin
            wsat[r] = SAT_MAX;
         end else if (wsum[r] < 49'(SAT_MIN)) begin
            wsat[r] = SAT_MIN;
         end else begin
            wsat[r] = wsum[r][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en.st5) begin
         rsp_ff.world_x     <= wsat[0];
         rsp_ff.world_y     <= wsat[1];
         rsp_ff.world_z     <= wsat[2];
         rsp_ff.slot_out    <= slot4_ff;
         rsp_ff.marker_type <= type4_ff;
         rsp_ff.store       <= store4_ff;
      end
   end

   assign rsp = rsp_ff;

endmodule

// ----- rtl/camera_to_world_pose_transform.sv -----
// ----------------------------------------------------------------------------
// camera_to_world_pose_transform
// Marker position from camera frame to world frame, with store flag.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_data (req_type)
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_data (rsp_type)
//  csr     | in        | csr_we               | csr_index, csr_wdata
//
//  Five register stages, rsp_valid being registered from the fifth; one
//  transaction per cycle sustained while rsp_ready stays high. The pipeline
//  holds two multiply levels (camera matrix, rotation matrix), each followed
//  by a sum stage.
//  Each stage holds while its successor is full and stalled; bubbles close up.
//  Synchronous reset clears the valid bits and loads the csr reset values.
// ----------------------------------------------------------------------------
`include "camera_to_world_pose_transform_assert.svh"

module camera_to_world_pose_transform
   import cwpt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rot        <= {54'd2251799813685248, 54'd8589934592, 54'd32768};
         cfg_ff.offset     <= '0;
         cfg_ff.max_error  <= '0;
         cfg_ff.img_width  <= 16'd640;
         cfg_ff.img_height <= 16'd480;
         cfg_ff.types      <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ROT_ROW0:   cfg_ff.rot[0]     <= csr_wdata[53:0];
            REG_ROT_ROW1:   cfg_ff.rot[1]     <= csr_wdata[53:0];
            REG_ROT_ROW2:   cfg_ff.rot[2]     <= csr_wdata[53:0];
            REG_OFFSET:     cfg_ff.offset     <= csr_wdata[59:0];
            REG_MAX_ERROR:  cfg_ff.max_error  <= csr_wdata[62:0];
            REG_IMG_WIDTH:  cfg_ff.img_width  <= csr_wdata[15:0];
            REG_IMG_HEIGHT: cfg_ff.img_height <= csr_wdata[15:0];
            REG_TYPES:      cfg_ff.types      <= csr_wdata[47:0];
            default: ;
         endcase
      end
   end

   logic [5:1] vld_ff, vld_in;
   stage_en_type en;

   always_comb begin
      en.st5 = !vld_ff[5] || rsp_ready;
      en.st4 = !vld_ff[4] || en.st5;
      en.st3 = !vld_ff[3] || en.st4;
      en.st2 = !vld_ff[2] || en.st3;
      en.st1 = !vld_ff[1] || en.st2;
      vld_in[1] = en.st1 ? req_valid : vld_ff[1];
      vld_in[2] = en.st2 ? vld_ff[1] : vld_ff[2];
      vld_in[3] = en.st3 ? vld_ff[2] : vld_ff[3];
      vld_in[4] = en.st4 ? vld_ff[3] : vld_ff[4];
      vld_in[5] = en.st5 ? vld_ff[4] : vld_ff[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = en.st1;
   assign rsp_valid = vld_ff[5];

   mid_type mid;

   cwpt_body u_body (
      .clock (clock),
      .req   (req_data),
      .cfg   (cfg_ff),
      .en    (en),
      .mid   (mid)
   );

   cwpt_world u_world (
      .clock (clock),
      .mid   (mid),
      .en    (en),
      .rsp   (rsp_data)
   );

   `CWPT_ASSERT(a_accept_lands, (req_valid && req_ready) |=> vld_ff[1])
   `CWPT_ASSERT(a_mid_hold, (vld_ff[3] && !en.st4) |=> vld_ff[3])
   `CWPT_ASSERT(a_forced_store, (rsp_valid && (rsp_data.marker_type == TYPE_ALWAYS_STORE)) |-> rsp_data.store)
   `CWPT_NEVER(a_ready_when_full, req_ready && (&vld_ff) && !rsp_ready)

endmodule

// ----- tb/sv/tb_camera_to_world_pose_transform.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_camera_to_world_pose_transform
// Drives marker detections with random gaps and back-pressure, predicts the
// world position, marker type and store flag in fixed point, and checks every
// response in order. Several register settings are swept between phases.
// ----------------------------------------------------------------------------
module tb_camera_to_world_pose_transform;
   import cwpt_pkg::*;

   localparam int LATENCY   = 5;
   localparam int WDOG_MAX  = 4000;
   localparam int N_RANDOM  = 590;
   localparam int LONG_HOLD = 60;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   req_type req_data;
   rsp_type rsp_data;
   logic csr_we;
   csr_index_type csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   camera_to_world_pose_transform dut (.*);

   // predictor copy of the registers
   logic [53:0] rot_row [3];
   logic [59:0] cam_ofs;
   logic [62:0] max_err;
   logic [15:0] img_w, img_h;
   logic [47:0] type_codes;

   req_type pending_q [$];
   rsp_type world_q [$];
   int errors = 0;
   int checked = 0;
   int stored = 0;
   int idle_cnt = 0;
   bit hold_go = 0;
   bit hold_done = 0;
   int hold_left = 0;
   int gap_left = 0, stall_left = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic longint round_shr(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint sx18(logic [17:0] v);
      return longint'($signed(v));
   endfunction

   function automatic rsp_type world_pose(req_type t);
      rsp_type o;
      longint p[3], b[3], veh[3], rq[3][3], acc, qx, qy, qz, qw, one, w, dx, dy;
      longint unsigned sqx, sqy;
      logic signed [15:0] mt;
      qx = t.quat_x; qy = t.quat_y; qz = t.quat_z; qw = t.quat_w;
      one = longint'(1) << 28;
      veh[0] = t.vehicle_x; veh[1] = t.vehicle_y; veh[2] = t.vehicle_z;
      p[0] = t.cam_x; p[1] = t.cam_y; p[2] = longint'(t.cam_z) - veh[2];
      for (int r = 0; r < 3; r++) begin
         acc = longint'($signed(cam_ofs[20*r +: 20])) * 65536;
         for (int c = 0; c < 3; c++)
            acc += sx18(rot_row[r][18*c +: 18]) * p[c];
         b[r] = round_shr(acc, 15);
      end
      rq[0][0] = one - 2*(qy*qy + qz*qz); rq[0][1] = 2*(qx*qy - qz*qw);
      rq[0][2] = 2*(qx*qz + qy*qw);       rq[1][0] = 2*(qx*qy + qz*qw);
      rq[1][1] = one - 2*(qx*qx + qz*qz); rq[1][2] = 2*(qy*qz - qx*qw);
      rq[2][0] = 2*(qx*qz - qy*qw);       rq[2][1] = 2*(qy*qz + qx*qw);
      rq[2][2] = one - 2*(qx*qx + qy*qy);
      for (int r = 0; r < 3; r++) begin
         acc = 0;
         for (int c = 0; c < 3; c++)
            acc += round_shr(rq[r][c], 12) * b[c];
         w = round_shr(acc, 16) + veh[r];
         if (w > 64'sd2147483647) w = 64'sd2147483647;
         if (w < -64'sd2147483648) w = -64'sd2147483648;
         if (r == 0) o.world_x = w[31:0];
         else if (r == 1) o.world_y = w[31:0];
         else o.world_z = w[31:0];
      end
      mt = (t.slot == 2'd3) ? 16'sd0 : type_codes[16*t.slot +: 16];
      dx = p[0] - (longint'(img_h >> 1) << 16);
      dy = p[1] - (longint'(img_w >> 1) << 16);
      sqx = (dx < 0) ? longint'(-dx) : dx; sqx = sqx * sqx;
      sqy = (dy < 0) ? longint'(-dy) : dy; sqy = sqy * sqy;
      o.slot_out = t.slot;
      o.marker_type = mt;
      o.store = (sqx < max_err && sqy < max_err && sqx + sqy < max_err) ||
                mt == TYPE_ALWAYS_STORE;
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
         gap_left <= 0;
      end else if (req_valid && !req_ready) begin
      end else if (gap_left > 0) begin
         req_valid <= 0;
         gap_left <= gap_left - 1;
      end else if (pending_q.size() > 0) begin
         req_data <= pending_q[0];
         world_q = {world_q, world_pose(pending_q[0])};
         void'(pending_q.pop_front());
         req_valid <= 1;
         gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
      end else begin
         req_valid <= 0;
      end
   end

   // monitor and receiver stalls
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_ready <= 0;
         stall_left <= 0;
         hold_left <= 0;
         hold_done <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (world_q.size() == 0) begin
               errors++;
               $display("%0t unexpected transaction got %p", $time, rsp_data);
            end else begin
               e = world_q.pop_front();
               checked++;
               if (e.store) stored++;
               if (rsp_data !== e) begin
                  errors++;
                  $display("%0t mismatch expected %p actual %p", $time, e, rsp_data);
               end
            end
         end
         if (hold_left > 0) begin
            rsp_ready <= 0;
            hold_left <= hold_left - 1;
            if (hold_left == 1) hold_done <= 1;
         end else if (hold_go && !hold_done) begin
            rsp_ready <= 0;
            hold_left <= LONG_HOLD;
         end else if (stall_left > 0) begin
            rsp_ready <= 0;
            stall_left <= stall_left - 1;
         end else if (rsp_valid && rsp_ready || !rsp_ready) begin
            if ($urandom_range(0, 2) == 0) begin
               rsp_ready <= 0;
               stall_left <= $urandom_range(0, 12);
            end else begin
               rsp_ready <= 1;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (pending_q.size() == 0 && world_q.size() == 0))
         idle_cnt <= 0;
      else
         idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WDOG_MAX) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic write_reg(csr_index_type idx, logic [62:0] val);
      @(posedge clock);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      case (idx)
         REG_ROT_ROW0:   rot_row[0] = val[53:0];
         REG_ROT_ROW1:   rot_row[1] = val[53:0];
         REG_ROT_ROW2:   rot_row[2] = val[53:0];
         REG_OFFSET:     cam_ofs = val[59:0];
         REG_MAX_ERROR:  max_err = val;
         REG_IMG_WIDTH:  img_w = val[15:0];
         REG_IMG_HEIGHT: img_h = val[15:0];
         REG_TYPES:      type_codes = val[47:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic drain();
      while (pending_q.size() > 0 || world_q.size() > 0 || req_valid)
         @(posedge clock);
      repeat (LATENCY + 3) @(posedge clock);
   endtask

   function automatic logic signed [15:0] rand_quat();
      case ($urandom_range(0, 5))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'sd0;
         default: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
      endcase
   endfunction

   function automatic logic signed [31:0] rand_q16(int span);
      case ($urandom_range(0, 9))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom;
         default: return $signed(32'($urandom_range(0, 2*span))) - span;
      endcase
   endfunction

   function automatic req_type rand_item();
      req_type t;
      t.cam_x = ($urandom_range(0, 1)) ? (32'sd320 <<< 16) +
                $signed(32'($urandom_range(0, 1 << 22))) - (1 <<< 21)
                : rand_q16(1 << 24);
      t.cam_y = ($urandom_range(0, 1)) ? (32'sd240 <<< 16) +
                $signed(32'($urandom_range(0, 1 << 22))) - (1 <<< 21)
                : rand_q16(1 << 24);
      t.cam_z = rand_q16(1 << 24);
      t.quat_x = rand_quat(); t.quat_y = rand_quat();
      t.quat_z = rand_quat(); t.quat_w = rand_quat();
      t.vehicle_x = rand_q16(1 << 24);
      t.vehicle_y = rand_q16(1 << 24);
      t.vehicle_z = rand_q16(1 << 24);
      t.slot = 2'($urandom_range(0, 3));
      return t;
   endfunction

   task automatic random_phase(int n);
      repeat (n) pending_q = {pending_q, rand_item()};
   endtask

   initial begin
      req_type t;
      logic [53:0] r;
      reset = 1; req_valid = 0; rsp_ready = 0; req_data = '0;
      csr_we = 0; csr_index = REG_ROT_ROW0; csr_wdata = '0;
      rot_row[0] = 54'd32768; rot_row[1] = 54'd8589934592;
      rot_row[2] = 54'd2251799813685248;
      cam_ofs = '0; max_err = '0; img_w = 16'd640; img_h = 16'd480; type_codes = '0;
      repeat (7) @(posedge clock);
      reset <= 0;

      // directed: reset config, field extremes, every slot
      for (int i = 0; i < 16; i++) begin
         t = '0;
         t.quat_w = 16'sd16384;
         t.slot = 2'(i % 4);
         case (i)
            0: ;
            1: begin t.cam_x = 32'h7fffffff; t.cam_y = 32'h7fffffff;
                     t.cam_z = 32'h7fffffff; end
            2: begin t.cam_x = 32'h80000000; t.cam_y = 32'h80000000;
                     t.cam_z = 32'h80000000; end
            3: begin t.vehicle_x = 32'h7fffffff; t.vehicle_y = 32'h7fffffff;
                     t.vehicle_z = 32'h80000000; t.cam_x = 32'h7fffffff; end
            4: begin t.vehicle_x = 32'h80000000; t.vehicle_y = 32'h80000000;
                     t.vehicle_z = 32'h7fffffff; t.cam_y = 32'h80000000; end
            5: begin t.quat_x = 16'sd16384; t.quat_y = 16'sd16384;
                     t.quat_z = 16'sd16384; t.quat_w = 16'sd16384;
                     t.cam_x = 32'sd65536; end
            6: begin t.quat_x = -16'sd16384; t.quat_y = -16'sd16384;
                     t.quat_z = -16'sd16384; t.quat_w = -16'sd16384;
                     t.cam_y = 32'h7fffffff; end
            7: begin t.quat_w = '0; t.quat_z = 16'sd16384; t.cam_x = 32'sd1 <<< 20; end
            default: t = rand_item();
         endcase
         pending_q = {pending_q, t};
      end
      drain();

      // extreme settings, saturation, always-store type on slot 1, every slot driven
      write_reg(REG_ROT_ROW0, 63'({18'h1ffff, 18'h20000, 18'h1ffff}));
      write_reg(REG_ROT_ROW1, 63'({18'h20000, 18'h1ffff, 18'h20000}));
      write_reg(REG_ROT_ROW2, 63'({18'h3ffff, 18'h00001, 18'h20000}));
      write_reg(REG_OFFSET, 63'({20'h7ffff, 20'h80000, 20'hfffff}));
      write_reg(REG_MAX_ERROR, 63'h7fffffffffffffff);
      write_reg(REG_IMG_WIDTH, 63'(16'hffff));
      write_reg(REG_IMG_HEIGHT, 63'(16'h0000));
      write_reg(REG_TYPES, 63'({16'h7fff, TYPE_ALWAYS_STORE, 16'h8000}));
      for (int i = 0; i < 8; i++) begin
         t = rand_item();
         t.slot = 2'(i % 4);
         pending_q = {pending_q, t};
      end
      // receiver holds off while the sender keeps offering
      hold_go = 1;
      random_phase(40);
      wait (hold_done);
      hold_go = 0;
      drain();

      // pause-until-empty then several random settings
      for (int ph = 0; ph < 5; ph++) begin
         for (int k = 0; k < 3; k++) begin
            r = 54'({$urandom, $urandom});
            if (ph % 2 == 0) r[18*k +: 18] = 18'd32768;
            write_reg(csr_index_type'(k), 63'(r));
         end
         write_reg(REG_OFFSET, 63'({$urandom, $urandom}));
         write_reg(REG_MAX_ERROR,
                   (ph == 4) ? 63'd0 : 63'({$urandom, $urandom}) >> $urandom_range(10, 20));
         write_reg(REG_IMG_WIDTH,
                   63'((ph == 0) ? 16'hffff : 16'($urandom_range(0, 1280))));
         write_reg(REG_IMG_HEIGHT,
                   63'((ph == 1) ? 16'hffff : 16'($urandom_range(0, 960))));
         write_reg(REG_TYPES, 63'({16'($urandom),
                                   (ph == 2) ? TYPE_ALWAYS_STORE : 16'($urandom),
                                   16'($urandom)}));
         random_phase(N_RANDOM / 5);
         drain();
      end

      $display("Covered %0d responses over several register settings, %0d flagged store.",
               checked, stored);
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
